// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the 3x3 inverse block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low
`define MI3_ASSERT_IMP(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
    else $error("matrix3_inverse: assertion failed");

// Next-cycle implication, disabled while reset is low
`define MI3_ASSERT_NXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
    else $error("matrix3_inverse: assertion failed");

`endif

// ----- hdl/mi3_pkg.sv -----
// ----------------------------------------------------------------------------
// mi3_pkg
// Widths, stage types and helper functions for the 3x3 inverse pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package mi3_pkg;

  // Element, product and cofactor widths
  localparam int EW   = 32;          // Q16.16 element
  localparam int PW   = 2 * EW;      // 32x32 product, Q32.32
  localparam int CW   = PW + 1;      // cofactor
  localparam int HW   = CW - EW;     // upper slice of a cofactor
  localparam int PPW  = HW + EW;     // partial product for the determinant
  localparam int DW   = CW + EW + 2; // determinant, Q51.48
  localparam int DMW  = DW - 1;      // determinant magnitude
  localparam int NW   = CW + EW;     // divider numerator magnitude
  localparam int RW   = DMW + EW;    // divider compare width
  localparam int QW   = EW;          // quotient bits
  localparam int VW   = 64;          // det_value width
  localparam int SHW  = DMW - EW;    // determinant magnitude in Q50.16
  localparam int NSTG = QW + 2;      // divider stages: prep, overflow, one per bit

  localparam logic [QW-1:0] Q_MAX = {1'b0, {(QW-1){1'b1}}};
  localparam logic [QW-1:0] Q_MIN = {1'b1, {(QW-1){1'b0}}};
  localparam logic [VW-1:0] D_MAX = {1'b0, {(VW-1){1'b1}}};
  localparam logic [VW-1:0] D_MIN = {1'b1, {(VW-1){1'b0}}};

  typedef logic [8:0][EW-1:0] mat_t;

  // Cofactor stage internals
  typedef struct packed {
    logic [8:0][PW-1:0] pp;
    logic [8:0][PW-1:0] pq;
    logic [2:0][EW-1:0] row0;
  } prod_t;

  typedef struct packed {
    logic [8:0][CW-1:0] cof;
    logic [2:0][EW-1:0] row0;
  } cof_bus_t;

  // Determinant stage internals
  typedef struct packed {
    logic [2:0][PPW-1:0] ph;
    logic [2:0][PPW-1:0] pl;
    logic [8:0][CW-1:0]  cof;
  } dpart_t;

  typedef struct packed {
    logic [2:0][DW-1:0] t;
    logic [8:0][CW-1:0] cof;
  } dsum_t;

  typedef struct packed {
    logic [DW-1:0]      det;
    logic [8:0][CW-1:0] cof;
  } det_bus_t;

  // Divider stage state
  typedef struct packed {
    logic [8:0][NW-1:0] rem;
    logic [8:0][QW-1:0] q;
    logic [8:0]         ovf;
    logic [8:0]         neg;
    logic [DMW-1:0]     dmag;
    logic [VW-1:0]      dv;
    logic               sing;
  } div_st_t;

  // Minor row/column helpers: the two indices left when k is struck out
  function automatic int lo_idx(input int k);
    return (k == 0) ? 1 : 0;
  endfunction

  function automatic int hi_idx(input int k);
    return (k == 2) ? 1 : 2;
  endfunction

  // Signed saturation of a quotient magnitude; zero when singular
  function automatic logic [QW-1:0] sat_q(input logic ovf, input logic neg,
                                          input logic sing, input logic [QW-1:0] q);
    logic [QW-1:0] res;
    if (sing) begin
      res = '0;
    end else if (!neg) begin
      res = (ovf || (q > Q_MAX)) ? Q_MAX : q;
    end else begin
      res = (ovf || (q > Q_MIN)) ? Q_MIN : (~q + 1'b1);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/mi3_if.sv -----
// ----------------------------------------------------------------------------
// mi3_if
// Handshake channels of the 3x3 inverse: matrix in, inverse out.
// ----------------------------------------------------------------------------
`default_nettype none

interface mi3_in_if import mi3_pkg::*; ();
  logic              valid;
  logic              ready;
  logic signed [EW-1:0] a00, a01, a02, a10, a11, a12, a20, a21, a22;

  modport source (output valid, a00, a01, a02, a10, a11, a12, a20, a21, a22,
                  input ready);
  modport sink   (input valid, a00, a01, a02, a10, a11, a12, a20, a21, a22,
                  output ready);
endinterface

interface mi3_out_if import mi3_pkg::*; ();
  logic              valid;
  logic              ready;
  logic signed [EW-1:0] inv00, inv01, inv02, inv10, inv11, inv12, inv20, inv21, inv22;
  logic signed [VW-1:0] det_value;
  logic              singular;

  modport source (output valid, inv00, inv01, inv02, inv10, inv11, inv12,
                  inv20, inv21, inv22, det_value, singular, input ready);
  modport sink   (input valid, inv00, inv01, inv02, inv10, inv11, inv12,
                  inv20, inv21, inv22, det_value, singular, output ready);
endinterface

`default_nettype wire

// ----- hdl/matrix3_inverse.sv -----
// ----------------------------------------------------------------------------
// matrix3_inverse
// Fully pipelined 3x3 Q16.16 matrix inverse by adjugate and determinant.
// ----------------------------------------------------------------------------
// Usage:
//   in_mat  : one item is a 3x3 matrix, a00..a22, signed Q16.16.
//   out_inv : one item per input: inv00..inv22 (Q16.16, saturated), det_value
//             (Q16.16 in 64 bits, saturated) and singular. A zero determinant
//             sets singular and forces the inverse and det_value to zero.
//   Both channels move an item when valid and ready are high at a clock edge.
//   Throughput: one item per cycle while out_inv.ready stays high. From
//   acceptance to out_inv.valid an item passes two cofactor stages, three
//   determinant stages, the 34-stage divider (prep, overflow check, one
//   quotient bit per stage) and the output register.
//   Each stage holds its item while the one after it is full and stalled;
//   empty stages keep filling, so input is taken until the whole pipe is full.
//   Nothing is lost or repeated while out_inv.ready is low.
//   Reset (rst_n low, synchronous) clears every valid bit; payload registers are not reset.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module matrix3_inverse import mi3_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  mi3_in_if.sink   in_mat,
  mi3_out_if.source out_inv
);

  mat_t     mat;
  logic     cof_valid, cof_ready;
  cof_bus_t cof_data;
  logic     det_valid, det_ready;
  det_bus_t det_data;
  logic     div_valid, div_ready;
  div_st_t  div_data;

  logic                 out_valid_r;
  logic [8:0][QW-1:0]   inv_r, inv_nxt;
  logic [VW-1:0]        det_r;
  logic                 sing_r;

  assign mat = {in_mat.a22, in_mat.a21, in_mat.a20,
                in_mat.a12, in_mat.a11, in_mat.a10,
                in_mat.a02, in_mat.a01, in_mat.a00};

  mi3_cof u_cof (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_mat.valid),
    .up_ready (in_mat.ready),
    .up_mat   (mat),
    .dn_valid (cof_valid),
    .dn_ready (cof_ready),
    .dn_data  (cof_data)
  );

  mi3_det u_det (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (cof_valid),
    .up_ready (cof_ready),
    .up_data  (cof_data),
    .dn_valid (det_valid),
    .dn_ready (det_ready),
    .dn_data  (det_data)
  );

  mi3_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (det_valid),
    .up_ready (det_ready),
    .up_data  (det_data),
    .dn_valid (div_valid),
    .dn_ready (div_ready),
    .dn_data  (div_data)
  );

  // output register: saturate quotients, zero on singular
  assign div_ready = !out_valid_r || out_inv.ready;

  always_comb begin
    for (int k = 0; k < 9; k++) begin
      inv_nxt[k] = sat_q(div_data.ovf[k], div_data.neg[k], div_data.sing, div_data.q[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (div_ready) begin
      out_valid_r <= div_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (div_ready) begin
      inv_r  <= inv_nxt;
      det_r  <= div_data.dv;
      sing_r <= div_data.sing;
    end
  end

  assign out_inv.valid     = out_valid_r;
  assign out_inv.inv00     = inv_r[0];
  assign out_inv.inv01     = inv_r[1];
  assign out_inv.inv02     = inv_r[2];
  assign out_inv.inv10     = inv_r[3];
  assign out_inv.inv11     = inv_r[4];
  assign out_inv.inv12     = inv_r[5];
  assign out_inv.inv20     = inv_r[6];
  assign out_inv.inv21     = inv_r[7];
  assign out_inv.inv22     = inv_r[8];
  assign out_inv.det_value = det_r;
  assign out_inv.singular  = sing_r;

  // checks
  `MI3_ASSERT_IMP(a_sing_inv_zero, clk, rst_n, out_valid_r && sing_r, inv_r == '0)
  `MI3_ASSERT_IMP(a_sing_det_zero, clk, rst_n, out_valid_r && sing_r, det_r == '0)
  `MI3_ASSERT_IMP(a_reset_empty, clk, rst_n, $past(!rst_n), !out_valid_r)
  `MI3_ASSERT_NXT(a_hold_stall, clk, rst_n, out_valid_r && !out_inv.ready,
                  out_valid_r && $stable(inv_r) && $stable(det_r))

endmodule

`default_nettype wire

// ----- hdl/mi3_cof.sv -----
// ----------------------------------------------------------------------------
// mi3_cof
// Two stages: the eighteen 2x2 minor products, then signed cofactors.
// ----------------------------------------------------------------------------
`default_nettype none

module mi3_cof import mi3_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     up_valid,
  output logic     up_ready,
  input  mat_t     up_mat,
  output logic     dn_valid,
  input  logic     dn_ready,
  output cof_bus_t dn_data
);

  logic     v1_r, v2_r;
  logic     en1, en2;
  prod_t    prod_r, prod_nxt;
  cof_bus_t cof_r, cof_nxt;

  // stage enables: move when empty or when downstream moves
  assign en2      = !v2_r || dn_ready;
  assign en1      = !v1_r || en2;
  assign up_ready = en1;
  assign dn_valid = v2_r;
  assign dn_data  = cof_r;

  // minor products
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        prod_nxt.pp[r*3+c] = $signed(up_mat[lo_idx(r)*3 + lo_idx(c)])
                           * $signed(up_mat[hi_idx(r)*3 + hi_idx(c)]);
        prod_nxt.pq[r*3+c] = $signed(up_mat[lo_idx(r)*3 + hi_idx(c)])
                           * $signed(up_mat[hi_idx(r)*3 + lo_idx(c)]);
      end
    end
    prod_nxt.row0 = up_mat[2:0];
  end

  // minors with checkerboard signs
  always_comb begin
    logic signed [CW-1:0] m;
    m = '0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        m = CW'($signed(prod_r.pp[r*3+c])) - CW'($signed(prod_r.pq[r*3+c]));
        cof_nxt.cof[r*3+c] = (((r + c) % 2) == 1) ? -m : m;
      end
    end
    cof_nxt.row0 = prod_r.row0;
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (en1) v1_r <= up_valid;
      if (en2) v2_r <= v1_r;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (en1) prod_r <= prod_nxt;
    if (en2) cof_r  <= cof_nxt;
  end

endmodule

`default_nettype wire

// ----- hdl/mi3_det.sv -----
// ----------------------------------------------------------------------------
// mi3_det
// Three stages: split cofactor products, recombine, row-0 determinant sum.
// ----------------------------------------------------------------------------
`default_nettype none

module mi3_det import mi3_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     up_valid,
  output logic     up_ready,
  input  cof_bus_t up_data,
  output logic     dn_valid,
  input  logic     dn_ready,
  output det_bus_t dn_data
);

  logic     v1_r, v2_r, v3_r;
  logic     en1, en2, en3;
  dpart_t   part_r, part_nxt;
  dsum_t    sum_r, sum_nxt;
  det_bus_t det_r, det_nxt;

  assign en3      = !v3_r || dn_ready;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign up_ready = en1;
  assign dn_valid = v3_r;
  assign dn_data  = det_r;

  // cofactor split into upper signed and lower unsigned halves
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      part_nxt.ph[c] = $signed(up_data.cof[c][CW-1:EW]) * $signed(up_data.row0[c]);
      part_nxt.pl[c] = $signed({1'b0, up_data.cof[c][EW-1:0]})
                     * $signed(up_data.row0[c]);
    end
    part_nxt.cof = up_data.cof;
  end

  // full products
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sum_nxt.t[c] = (DW'($signed(part_r.ph[c])) <<< EW) + DW'($signed(part_r.pl[c]));
    end
    sum_nxt.cof = part_r.cof;
  end

  // expansion along row 0
  always_comb begin
    det_nxt.det = sum_r.t[0] + sum_r.t[1] + sum_r.t[2];
    det_nxt.cof = sum_r.cof;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (en1) v1_r <= up_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) part_r <= part_nxt;
    if (en2) sum_r  <= sum_nxt;
    if (en3) det_r  <= det_nxt;
  end

endmodule

`default_nettype wire

// ----- hdl/mi3_div.sv -----
// ----------------------------------------------------------------------------
// mi3_div
// Nine-lane pipelined restoring divider: adjugate * 2^32 / determinant.
// ----------------------------------------------------------------------------
`default_nettype none

module mi3_div import mi3_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     up_valid,
  output logic     up_ready,
  input  det_bus_t up_data,
  output logic     dn_valid,
  input  logic     dn_ready,
  output div_st_t  dn_data
);

  logic [NSTG-1:0] v_r;
  logic [NSTG-1:0] v_in;
  logic [NSTG-1:0] en;
  div_st_t         st_r   [NSTG];
  div_st_t         st_nxt [NSTG];

  // a stage moves if any stage from it onward is empty, or the output moves
  always_comb begin
    for (int k = 0; k < NSTG; k++) begin
      en[k] = dn_ready || ((~v_r & ({NSTG{1'b1}} << k)) != '0);
    end
  end

  assign v_in     = {v_r[NSTG-2:0], up_valid};
  assign up_ready = en[0];
  assign dn_valid = v_r[NSTG-1];
  assign dn_data  = st_r[NSTG-1];

  // prep: magnitudes, signs, det_value saturation
  always_comb begin
    logic           dneg;
    logic [DW-1:0]  dabs;
    logic [SHW-1:0] sh;
    logic [CW-1:0]  adj;
    logic [CW-1:0]  amag;
    dneg = up_data.det[DW-1];
    dabs = dneg ? (~up_data.det + 1'b1) : up_data.det;
    st_nxt[0].dmag = dabs[DMW-1:0];
    st_nxt[0].sing = (dabs == '0);
    sh = dabs[DMW-1:EW];
    if (!dneg) begin
      st_nxt[0].dv = (sh > SHW'(D_MAX)) ? D_MAX : sh[VW-1:0];
    end else begin
      st_nxt[0].dv = (sh > SHW'(D_MIN)) ? D_MIN : (~sh[VW-1:0] + 1'b1);
    end
    adj  = '0;
    amag = '0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        adj  = up_data.cof[c*3+r];
        amag = adj[CW-1] ? (~adj + 1'b1) : adj;
        st_nxt[0].rem[r*3+c] = {amag, {EW{1'b0}}};
        st_nxt[0].neg[r*3+c] = adj[CW-1] ^ dneg;
      end
    end
    st_nxt[0].q   = '0;
    st_nxt[0].ovf = '0;
  end

  // overflow: quotient would need more than QW bits
  always_comb begin
    st_nxt[1] = st_r[0];
    for (int k = 0; k < 9; k++) begin
      st_nxt[1].ovf[k] = {{(RW-NW){1'b0}}, st_r[0].rem[k]}
                       >= {st_r[0].dmag, {EW{1'b0}}};
    end
  end

  // one quotient bit per stage, most significant first
  for (genvar g = 2; g < NSTG; g++) begin : g_step
    localparam int SH = QW - 1 - (g - 2);
    always_comb begin
      logic [RW-1:0] dsh;
      logic [RW-1:0] rw;
      st_nxt[g] = st_r[g-1];
      dsh = RW'(st_r[g-1].dmag) << SH;
      rw  = '0;
      for (int k = 0; k < 9; k++) begin
        rw = RW'(st_r[g-1].rem[k]);
        if (rw >= dsh) begin
          st_nxt[g].rem[k]   = NW'(rw - dsh);
          st_nxt[g].q[k][SH] = 1'b1;
        end
      end
    end
  end

  for (genvar g = 0; g < NSTG; g++) begin : g_reg
    always_ff @(posedge clk) begin
      if (en[g]) st_r[g] <= st_nxt[g];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 0; k < NSTG; k++) begin
        if (en[k]) v_r[k] <= v_in[k];
      end
    end
  end

endmodule

`default_nettype wire
